// ----- rtl/est_pkg.sv -----
// ----------------------------------------------------------------------------
// est_pkg
// Types, codes and sizes shared by the event slot table and its cells.
// ----------------------------------------------------------------------------
package est_pkg;

    localparam int SLOTS      = 16;
    localparam int ID_WIDTH   = 32;
    localparam int DATA_WIDTH = 32;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef logic [ID_WIDTH-1:0]   id_t;
    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [SLOT_W-1:0]     slot_idx_t;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_NOTIFY = 3'd1,
        OP_POLL   = 3'd2,
        OP_REMOVE = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_FREE      = 2'd0,
        ST_ARMED     = 2'd1,
        ST_SIGNALLED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RC_OK   = 2'd0,
        RC_NONE = 2'd1,
        RC_FULL = 2'd2
    } rc_t;

    typedef enum logic [1:0] {
        FSM_IDLE    = 2'd0,
        FSM_COMPARE = 2'd1,
        FSM_RESOLVE = 2'd2
    } fsm_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        op_t   op;
        logic  compare;
        logic  commit;
        logic  any_hit;
        id_t   id;
        data_t data;
        id_t   timer_id;
    } ctrl_t;

    // Priority chain running from slot 0 upwards.
    typedef struct packed {
        logic hit;
        logic sig;
    } lo_chain_t;

    // What a cell reports when it is the one picked.
    typedef struct packed {
        logic  pick;
        id_t   id;
        data_t data;
    } cell_out_t;

endpackage

// ----- rtl/event_slot_table_top.sv -----
// ----------------------------------------------------------------------------
// event_slot_table_top
// Table of event slots built as a row of cells with add, notify, poll,
// remove and clear commands.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Beat contents
// s_*       in         command: op, event_id, event_data
// m_*       out        result: result_code, slot_index, out_id, out_data
// cfg_*     in         timer_event_id write
//
// Each command passes through a compare state, in which every cell compares
// its slot with the command, and a resolve state, in which the priority
// chains through the row of cells pick a slot and the result is written to
// the output register. The next command is taken in the same cycle as the
// result is registered, so a new command waits until the last is resolved.
// Reset leaves slot 0 armed with id zero and every other slot free.
// A stalled output holds the resolve cycle until the waiting beat is taken.
//
module event_slot_table_top
(
    input  logic        clk,
    input  logic        rst_n,
    // Command stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // op[2:0], event_id[34:3], event_data[66:35], zero pad
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // result_code[1:0], slot_index[5:2], out_id[37:6],
                                   // out_data[69:38], zero pad
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data   // timer_event_id
);

    est_pkg::fsm_t      state_reg, state_next;
    est_pkg::op_t       op_reg;
    est_pkg::id_t       id_reg;
    est_pkg::data_t     data_reg;
    est_pkg::id_t       timer_id_reg;

    logic               m_valid_reg, m_valid_next;
    est_pkg::rc_t       rc_reg, rc_next;
    logic [3:0]         idx_reg, idx_next;
    logic [31:0]        oid_reg, oid_next;
    logic [31:0]        odata_reg, odata_next;

    logic               accept;
    logic               commit;
    logic               compare;

    est_pkg::ctrl_t     ctrl;
    est_pkg::lo_chain_t lo_chain [est_pkg::SLOTS+1];
    logic               free_chain [est_pkg::SLOTS+1];
    est_pkg::cell_out_t cells_out [est_pkg::SLOTS];
    logic [est_pkg::SLOTS-1:0] pick_vec;

    logic               any_hit, any_sig, any_free;
    est_pkg::slot_idx_t sel_idx;
    est_pkg::id_t       sel_id;
    est_pkg::data_t     sel_data;

    // The register may be written at any time; it is sampled only on clear.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timer_id_reg <= '0;
        else if (cfg_valid && cfg_ready)
            timer_id_reg <= est_pkg::id_t'(cfg_data);
    end

    // Controller: next state.
    always_comb
    begin
        unique case (state_reg)
            est_pkg::FSM_IDLE:
                state_next = s_tvalid ? est_pkg::FSM_COMPARE : est_pkg::FSM_IDLE;
            est_pkg::FSM_COMPARE:
                state_next = est_pkg::FSM_RESOLVE;
            est_pkg::FSM_RESOLVE:
            begin
                if (!commit)
                    state_next = est_pkg::FSM_RESOLVE;
                else if (s_tvalid)
                    state_next = est_pkg::FSM_COMPARE;
                else
                    state_next = est_pkg::FSM_IDLE;
            end
            default:
                state_next = est_pkg::FSM_IDLE;
        endcase
    end

    // Controller: outputs. The result is registered only when the output
    // register is empty or is being emptied in this cycle.
    always_comb
    begin
        commit   = 1'b0;
        compare  = 1'b0;
        s_tready = 1'b0;
        unique case (state_reg)
            est_pkg::FSM_IDLE:
                s_tready = 1'b1;
            est_pkg::FSM_COMPARE:
                compare = 1'b1;
            est_pkg::FSM_RESOLVE:
            begin
                commit   = !m_valid_reg || m_tready;
                s_tready = commit;
            end
            default:
                s_tready = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= est_pkg::FSM_IDLE;
        else
            state_reg <= state_next;
    end

    // Command register, loaded on every accepted beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= est_pkg::op_t'(s_tdata[2:0]);
            id_reg   <= est_pkg::id_t'(s_tdata[34:3]);
            data_reg <= est_pkg::data_t'(s_tdata[66:35]);
        end
    end

    assign ctrl.op       = op_reg;
    assign ctrl.compare  = compare;
    assign ctrl.commit   = commit;
    assign ctrl.any_hit  = any_hit;
    assign ctrl.id       = id_reg;
    assign ctrl.data     = data_reg;
    assign ctrl.timer_id = timer_id_reg;

    // Row of cells. The hit and signalled chains run from slot 0 upwards so
    // the lowest match wins; the free chain runs downwards so the highest
    // free slot wins.
    assign lo_chain[0]               = '0;
    assign free_chain[est_pkg::SLOTS] = 1'b0;

    for (genvar i = 0; i < est_pkg::SLOTS; i++)
    begin : g_cell
        est_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .slot_num (est_pkg::slot_idx_t'(i)),
            .ctrl     (ctrl),
            .lo_in    (lo_chain[i]),
            .lo_out   (lo_chain[i+1]),
            .free_in  (free_chain[i+1]),
            .free_out (free_chain[i]),
            .cout     (cells_out[i])
        );
        assign pick_vec[i] = cells_out[i].pick;
    end

    assign any_hit  = lo_chain[est_pkg::SLOTS].hit;
    assign any_sig  = lo_chain[est_pkg::SLOTS].sig;
    assign any_free = free_chain[0];

    // At most one cell is picked, so its contents can be merged with an OR.
    always_comb
    begin
        sel_idx  = '0;
        sel_id   = '0;
        sel_data = '0;
        for (int i = 0; i < est_pkg::SLOTS; i++)
        begin
            if (cells_out[i].pick)
            begin
                sel_idx  = sel_idx | est_pkg::slot_idx_t'(i);
                sel_id   = sel_id | cells_out[i].id;
                sel_data = sel_data | cells_out[i].data;
            end
        end
    end

    // Result formation.
    always_comb
    begin
        rc_next    = est_pkg::RC_NONE;
        idx_next   = '0;
        oid_next   = '0;
        odata_next = '0;
        unique case (op_reg)
            est_pkg::OP_ADD:
            begin
                if (any_hit || any_free)
                begin
                    rc_next  = est_pkg::RC_OK;
                    idx_next = 4'(sel_idx);
                end
                else
                begin
                    rc_next = est_pkg::RC_FULL;
                end
            end
            est_pkg::OP_NOTIFY:
            begin
                if (any_hit)
                begin
                    rc_next  = est_pkg::RC_OK;
                    idx_next = 4'(sel_idx);
                end
            end
            est_pkg::OP_POLL:
            begin
                if (any_sig)
                begin
                    rc_next    = est_pkg::RC_OK;
                    idx_next   = 4'(sel_idx);
                    oid_next   = 32'(sel_id);
                    odata_next = 32'(sel_data);
                end
            end
            est_pkg::OP_REMOVE:
            begin
                if (any_hit)
                begin
                    rc_next    = est_pkg::RC_OK;
                    idx_next   = 4'(sel_idx);
                    oid_next   = 32'(sel_id);
                    odata_next = 32'(sel_data);
                end
            end
            est_pkg::OP_CLEAR:
                rc_next = est_pkg::RC_OK;
            default:
                rc_next = est_pkg::RC_NONE;
        endcase
    end

    // Output register.
    always_comb
    begin
        if (commit)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            rc_reg    <= rc_next;
            idx_reg   <= idx_next;
            oid_reg   <= oid_next;
            odata_reg <= odata_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, odata_reg, oid_reg, idx_reg, rc_reg};

`ifndef ASSERT_OFF
    // A registered result is always offered in the following cycle.
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> m_tvalid)
        else $error("result registered but not offered");

    // An accepted beat always starts a compare cycle.
    a_accept_compare: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == est_pkg::FSM_COMPARE))
        else $error("accepted beat did not start a compare");

    // Compare is followed by resolve without a gap.
    a_compare_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == est_pkg::FSM_COMPARE) |=> (state_reg == est_pkg::FSM_RESOLVE))
        else $error("compare not followed by resolve");

    // The priority chains pick at most one slot.
    a_one_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == est_pkg::FSM_RESOLVE) |-> $onehot0(pick_vec))
        else $error("more than one slot picked");

    // A result waiting on a stalled output is not overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !commit)
        else $error("waiting result overwritten");
`endif

endmodule

// ----- rtl/est_cell.sv -----
// ----------------------------------------------------------------------------
// est_cell
// One event slot: status, id and data, with its link in the priority chains.
// ----------------------------------------------------------------------------
module est_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  est_pkg::slot_idx_t   slot_num,
    input  est_pkg::ctrl_t       ctrl,
    input  est_pkg::lo_chain_t   lo_in,
    output est_pkg::lo_chain_t   lo_out,
    input  logic                 free_in,
    output logic                 free_out,
    output est_pkg::cell_out_t   cout
);

    est_pkg::status_t status_reg, status_next;
    est_pkg::id_t     id_reg, id_next;
    est_pkg::data_t   data_reg, data_next;
    logic             hit_reg, hit_next;
    logic             sig_reg, sig_next;
    logic             free_reg, free_next;
    logic             first_hit, first_sig, top_free, pick;

    // Flags from the compare cycle; the chains resolve priority across cells.
    assign lo_out.hit = lo_in.hit | hit_reg;
    assign lo_out.sig = lo_in.sig | sig_reg;
    assign free_out   = free_in | free_reg;

    assign first_hit = hit_reg & ~lo_in.hit;
    assign first_sig = sig_reg & ~lo_in.sig;
    assign top_free  = free_reg & ~free_in;

    always_comb
    begin
        unique case (ctrl.op)
            est_pkg::OP_ADD:    pick = ctrl.any_hit ? first_hit : top_free;
            est_pkg::OP_NOTIFY: pick = first_hit;
            est_pkg::OP_POLL:   pick = first_sig;
            est_pkg::OP_REMOVE: pick = first_hit;
            default:            pick = 1'b0;
        endcase
    end

    assign cout.pick = pick;
    assign cout.id   = id_reg;
    assign cout.data = data_reg;

    always_comb
    begin
        hit_next  = hit_reg;
        sig_next  = sig_reg;
        free_next = free_reg;
        if (ctrl.compare)
        begin
            hit_next  = (status_reg != est_pkg::ST_FREE) && (id_reg == ctrl.id);
            sig_next  = (status_reg == est_pkg::ST_SIGNALLED);
            free_next = (status_reg == est_pkg::ST_FREE);
        end
    end

    always_comb
    begin
        status_next = status_reg;
        id_next     = id_reg;
        data_next   = data_reg;
        if (ctrl.commit)
        begin
            unique case (ctrl.op)
                est_pkg::OP_ADD:
                begin
                    if (pick)
                    begin
                        data_next = ctrl.data;
                        if (!ctrl.any_hit)
                        begin
                            status_next = est_pkg::ST_ARMED;
                            id_next     = ctrl.id;
                        end
                    end
                end
                est_pkg::OP_NOTIFY:
                begin
                    if (pick)
                        status_next = est_pkg::ST_SIGNALLED;
                end
                est_pkg::OP_POLL:
                begin
                    if (pick)
                        status_next = est_pkg::ST_ARMED;
                end
                est_pkg::OP_REMOVE:
                begin
                    if (pick)
                        status_next = est_pkg::ST_FREE;
                end
                est_pkg::OP_CLEAR:
                begin
                    if (slot_num == '0)
                    begin
                        status_next = est_pkg::ST_ARMED;
                        id_next     = ctrl.timer_id;
                    end
                    else
                    begin
                        status_next = est_pkg::ST_FREE;
                    end
                end
                default:
                begin
                    status_next = status_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= (slot_num == '0) ? est_pkg::ST_ARMED : est_pkg::ST_FREE;
            id_reg     <= '0;
            hit_reg    <= 1'b0;
            sig_reg    <= 1'b0;
            free_reg   <= 1'b0;
        end
        else
        begin
            status_reg <= status_next;
            id_reg     <= id_next;
            hit_reg    <= hit_next;
            sig_reg    <= sig_next;
            free_reg   <= free_next;
        end
    end

    // Slot data must be written by the user before any meaningful read; the block does not enforce it. No reset.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for event_slot_table_top. A driver pushes command
// beats from a queue, an internal copy of the slot table predicts each result
// when its command is taken, and a monitor compares every result beat with
// the oldest prediction. The timer id register is changed between phases.
// ----------------------------------------------------------------------------
module tb;

    import est_pkg::*;

    // Command and result layouts, last declared field in the lowest bits.
    typedef struct packed {
        data_t      data;
        id_t        id;
        logic [2:0] op;
    } cmd_t;

    typedef struct packed {
        data_t      data;
        id_t        id;
        slot_idx_t  slot;
        logic [1:0] rc;
    } res_t;

    localparam int CMD_BITS        = $bits(cmd_t);
    localparam int RES_BITS        = $bits(res_t);
    localparam int OP_FIRST_UNUSED = OP_CLEAR + 1;
    localparam int OP_LAST_UNUSED  = 7;
    localparam int ID_POOL         = 20;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 10;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    event_slot_table_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Commands waiting for the driver, and results predicted but not yet seen.
    cmd_t pending_cmds[$];
    res_t expected_results[$];

    // Our own copy of the slot table and of the timer id register.
    status_t slot_state[SLOTS];
    id_t     slot_key[SLOTS];
    data_t   slot_word[SLOTS];
    id_t     timer_id_copy;

    // Ids that random commands mostly draw from, so that adds, notifies and
    // removes keep hitting live slots and the table regularly fills up.
    id_t id_pool[ID_POOL];

    int          mismatch_count = 0;
    int          results_seen   = 0;
    logic        calm_tail      = 1'b0;
    int          idle_cycles    = 0;
    int          src_hold;
    int          src_run;
    int          snk_hold;
    int          snk_run;
    int unsigned src_roll;
    int unsigned snk_roll;

    // Apply one command to the table copy and return the result it must give.
    function automatic res_t slot_apply(input cmd_t c);
        res_t r;
        int   hit;
        int   spare;
        int   sig;
        r     = '0;
        r.rc  = RC_OK;
        hit   = -1;
        spare = -1;
        sig   = -1;
        // Walk downwards so that the lowest index wins for matches and
        // signalled slots, and upwards so that the highest index wins for free slots.
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (slot_state[i] != ST_FREE && slot_key[i] == c.id)
                hit = i;
            if (slot_state[i] == ST_SIGNALLED)
                sig = i;
        end
        for (int i = 0; i < SLOTS; i++)
            if (slot_state[i] == ST_FREE)
                spare = i;
        case (c.op)
            OP_ADD:
            begin
                if (hit >= 0)
                begin
                    slot_word[hit] = c.data;
                    r.slot         = slot_idx_t'(hit);
                end
                else if (spare < 0)
                    r.rc = RC_FULL;
                else
                begin
                    slot_state[spare] = ST_ARMED;
                    slot_key[spare]   = c.id;
                    slot_word[spare]  = c.data;
                    r.slot            = slot_idx_t'(spare);
                end
            end
            OP_NOTIFY:
            begin
                if (hit < 0)
                    r.rc = RC_NONE;
                else
                begin
                    slot_state[hit] = ST_SIGNALLED;
                    r.slot          = slot_idx_t'(hit);
                end
            end
            OP_POLL:
            begin
                if (sig < 0)
                    r.rc = RC_NONE;
                else
                begin
                    slot_state[sig] = ST_ARMED;
                    r.slot          = slot_idx_t'(sig);
                    r.id            = slot_key[sig];
                    r.data          = slot_word[sig];
                end
            end
            OP_REMOVE:
            begin
                if (hit < 0)
                    r.rc = RC_NONE;
                else
                begin
                    slot_state[hit] = ST_FREE;
                    r.slot          = slot_idx_t'(hit);
                    r.id            = slot_key[hit];
                    r.data          = slot_word[hit];
                end
            end
            OP_CLEAR:
            begin
                // Data words survive a clear; only status and slot 0's id change.
                for (int i = 0; i < SLOTS; i++)
                    slot_state[i] = ST_FREE;
                slot_state[0] = ST_ARMED;
                slot_key[0]   = timer_id_copy;
            end
            default:
                r.rc = RC_NONE;
        endcase
        return r;
    endfunction

    function automatic void push_cmd(input logic [2:0] op, input id_t id, input data_t data);
        cmd_t c;
        c.op   = op;
        c.id   = id;
        c.data = data;
        pending_cmds.push_back(c);
    endfunction

    // A fresh set of ids for a phase; the timer id and both extremes are
    // always among them so that slot 0 and corner values see traffic.
    function automatic void refill_ids();
        for (int i = 0; i < ID_POOL; i++)
            id_pool[i] = id_t'($urandom);
        id_pool[0] = timer_id_copy;
        id_pool[1] = '0;
        id_pool[2] = '1;
    endfunction

    function automatic id_t pick_id();
        if ($urandom_range(0, 9) == 0)
            return id_t'($urandom);
        return id_pool[$urandom_range(0, ID_POOL - 1)];
    endfunction

    function automatic data_t pick_data();
        int unsigned roll;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return data_t'($urandom);
    endfunction

    // Mostly well-formed traffic on pooled ids, with a few clears and a
    // sprinkling of unused op codes carrying random fields.
    function automatic void queue_random(input int count);
        int unsigned roll;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 36)
                push_cmd(OP_ADD, pick_id(), pick_data());
            else if (roll < 56)
                push_cmd(OP_NOTIFY, pick_id(), pick_data());
            else if (roll < 74)
                push_cmd(OP_POLL, id_t'($urandom), pick_data());
            else if (roll < 90)
                push_cmd(OP_REMOVE, pick_id(), pick_data());
            else if (roll < 93)
                push_cmd(OP_CLEAR, id_t'($urandom), pick_data());
            else
                push_cmd(3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)),
                         id_t'($urandom), data_t'($urandom));
        end
    endfunction

    // Sampled on the falling edge so that every update of the rising edge
    // has settled.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    // Only called while the block is idle.
    task automatic set_timer_id(input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        timer_id_copy = id_t'(value);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_result(input res_t got);
        res_t want;
        results_seen++;
        if (expected_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("result beat %0d with nothing outstanding: rc %0d slot %0d id %h data %h",
                         results_seen, got.rc, got.slot, got.id, got.data);
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.rc !== want.rc || got.slot !== want.slot ||
                got.id !== want.id || got.data !== want.data)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("result beat %0d: expected rc %0d slot %0d id %h data %h",
                             results_seen, want.rc, want.slot, want.id, want.data);
                    $display("result beat %0d: got      rc %0d slot %0d id %h data %h",
                             results_seen, got.rc, got.slot, got.id, got.data);
                end
            end
        end
    endtask

    // Command driver. A beat, once offered, is held until it is taken;
    // between beats the driver idles in short random bursts, with the odd
    // longer stretch of back-to-back traffic.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_hold <= 0;
            src_run  <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            // A beat taken at this edge is predicted here, in issue order.
            if (s_tvalid)
                expected_results.push_back(slot_apply(cmd_t'(s_tdata[CMD_BITS-1:0])));
            src_roll = $urandom_range(0, 15);
            if (src_hold > 0)
            begin
                src_hold <= src_hold - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_cmds.size() == 0)
                s_tvalid <= 1'b0;
            else if (!calm_tail && src_run == 0 && src_roll < 4)
            begin
                src_hold <= $urandom_range(0, 6);
                s_tvalid <= 1'b0;
            end
            else
            begin
                if (src_run > 0)
                    src_run <= src_run - 1;
                else if (src_roll == 15)
                    src_run <= $urandom_range(16, 48);
                s_tvalid <= 1'b1;
                s_tdata  <= {{(72 - CMD_BITS){1'b0}}, pending_cmds.pop_front()};
            end
        end
    end

    // Result monitor with its own random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_hold <= 0;
            snk_run  <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result(res_t'(m_tdata[RES_BITS-1:0]));
            snk_roll = $urandom_range(0, 15);
            if (snk_hold > 0)
            begin
                snk_hold <= snk_hold - 1;
                m_tready <= 1'b0;
            end
            else if (!calm_tail && snk_run == 0 && snk_roll < 4)
            begin
                snk_hold <= $urandom_range(0, 6);
                m_tready <= 1'b0;
            end
            else
            begin
                if (snk_run > 0)
                    snk_run <= snk_run - 1;
                else if (snk_roll == 15)
                    snk_run <= $urandom_range(16, 48);
                m_tready <= 1'b1;
            end
        end
    end

    // Ends the run if no channel has moved a beat for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL event_slot_table_top");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        // Table copy as it comes out of reset: slot 0 armed with id zero.
        timer_id_copy = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_state[i] = ST_FREE;
            slot_key[i]   = '0;
            slot_word[i]  = '0;
        end
        slot_state[0] = ST_ARMED;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The first add hits slot 0 by its id, so slot 0's data
        // is written before anything can poll or remove it.
        push_cmd(OP_ADD, '0, '1);
        push_cmd(OP_NOTIFY, '0, '0);
        push_cmd(OP_POLL, '0, '0);             // slot 0 comes back re-armed
        push_cmd(OP_POLL, '1, '1);             // nothing left signalled
        push_cmd(OP_REMOVE, 32'h1357_9BDF, '0); // no such id
        // Fill every free slot, highest index first, then overflow.
        push_cmd(OP_ADD, '1, '0);
        for (int i = 1; i < SLOTS - 1; i++)
            push_cmd(OP_ADD, id_t'(i), data_t'($urandom));
        push_cmd(OP_ADD, 32'hA5A5_A5A5, 32'h0F0F_0F0F);  // table full
        push_cmd(OP_ADD, '1, 32'h5A5A_5A5A);             // update in place when full
        push_cmd(OP_REMOVE, '1, '0);
        push_cmd(OP_CLEAR, '1, '1);
        push_cmd(3'(OP_FIRST_UNUSED), '1, '1);
        push_cmd(3'(OP_LAST_UNUSED), 32'h8000_0001, 32'h7FFF_FFFE);
        wait_drained();

        // Random phases, each under a different timer id and opened by a
        // clear so that slot 0 picks the new id up.
        set_timer_id('1);
        refill_ids();
        push_cmd(OP_CLEAR, '0, '0);
        queue_random(300);
        wait_drained();

        set_timer_id($urandom);
        refill_ids();
        push_cmd(OP_CLEAR, '0, '0);
        queue_random(300);
        wait_drained();

        set_timer_id('0);
        refill_ids();
        push_cmd(OP_CLEAR, '0, '0);
        queue_random(300);
        wait_drained();

        // Final phase runs flat out on both sides.
        calm_tail = 1'b1;
        set_timer_id($urandom);
        refill_ids();
        push_cmd(OP_CLEAR, '0, '0);
        queue_random(250);
        wait_drained();

        // Leave room for any stray beat after the last expected one.
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS event_slot_table_top");
        else
            $display("FAIL event_slot_table_top");
        $finish;
    end

endmodule
